// File: rtl/core/lzwvw_pkg.sv
// ----------------------------------------------------------------------------
// LZW variable-width decoder package
// Shared item types, operation and status codes, and code constants.
// ----------------------------------------------------------------------------
package lzwvw_pkg;

    // Operation codes of an input item
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_FEED  = 2'd1;
    localparam logic [1:0] OP_PULL  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // Finish status codes
    localparam logic [1:0] FS_RUNNING = 2'd0;
    localparam logic [1:0] FS_FULL    = 2'd1;
    localparam logic [1:0] FS_SHORT   = 2'd2;
    localparam logic [1:0] FS_ERROR   = 2'd3;

    // Decode phases
    localparam logic [1:0] PH_FIRST   = 2'd0;
    localparam logic [1:0] PH_NORMAL  = 2'd1;
    localparam logic [1:0] PH_LITERAL = 2'd2;

    // Code values and limits
    localparam logic [10:0] CLEAR_CODE       = 11'h100;
    localparam logic [10:0] END_CODE         = 11'h101;
    localparam logic [10:0] LAST_LITERAL     = 11'd255;
    localparam logic [11:0] FIRST_FREE       = 12'd257;
    localparam logic [11:0] FREE_AFTER_CLEAR = 12'd258;
    localparam logic [11:0] NEXT_MAX         = 12'd4095;
    localparam logic [3:0]  START_WIDTH      = 4'd9;
    localparam logic [3:0]  WIDTH_STOP       = 4'd12;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] data_byte;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last_byte;
        logic       accepted;
        logic [1:0] status;
    } out_t;

    // Classified command passed from the front to the back
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
    } cmd_t;

endpackage

// File: rtl/core/lzw_variable_width_decompressor.sv
// Flow: start, idle op, feed and a pull with nothing pending go from idle straight
//   to the result state; a pull that returns a byte first passes the stack-read
//   state, and a feed that expands a code first walks its dictionary chain.
// Throughput: one command at a time, the next taken once the result is accepted;
//   the chain walk reads one dictionary entry per cycle from the registered-read RAM.
// Reset: rst_n clears control state asynchronously; dictionary and stack RAMs are not.
// ----------------------------------------------------------------------------
// LZW variable-width decompressor top level
// Input command queue, decode back end and one-entry result queue.
// ----------------------------------------------------------------------------
module lzw_variable_width_decompressor #(
    parameter int DICT_DEPTH  = 2048,
    parameter int STACK_DEPTH = 2048,
    parameter int WALK_LIMIT  = 4000
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  lzwvw_pkg::in_t  in_item,
    output logic            empty,
    input  logic            pop,
    output lzwvw_pkg::out_t out_item,
    input  logic            cfg_write,
    input  logic [19:0]     cfg_data
);

    // Length register; the user must write it only while no transaction is in flight (not enforced)
    logic [19:0]     len_reg;

    // Front to back command channel
    logic            cmd_valid;
    lzwvw_pkg::cmd_t cmd;
    logic            cmd_take;

    // Back end result and output holding register
    logic            res_valid;
    lzwvw_pkg::out_t res;
    logic            res_ready;
    logic            oval_reg, oval_next;
    lzwvw_pkg::out_t obuf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else if (cfg_write)
        begin
            len_reg <= cfg_data;
        end
    end

    // The front keeps taking transactions while the back works on one
    lzwvw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    lzwvw_back #(
        .DICT_DEPTH  (DICT_DEPTH),
        .STACK_DEPTH (STACK_DEPTH),
        .WALK_LIMIT  (WALK_LIMIT)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_take      (cmd_take),
        .output_length (len_reg),
        .res_valid     (res_valid),
        .res           (res),
        .res_ready     (res_ready)
    );

    // Advance a result into the output register when it is free or being popped
    assign res_ready = !oval_reg || pop;
    assign empty     = !oval_reg;
    assign out_item  = obuf_reg;

    always_comb
    begin
        oval_next = oval_reg;
        if (pop && oval_reg)
        begin
            oval_next = 1'b0;
        end
        if (res_valid && res_ready)
        begin
            oval_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oval_reg <= 1'b0;
        end
        else
        begin
            oval_reg <= oval_next;
        end
    end

    // Hold the result payload until popped
    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            obuf_reg <= res;
        end
    end

endmodule

// File: rtl/core/lzwvw_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lzwvw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/lzwvw_front.sv
// ----------------------------------------------------------------------------
// LZW decoder front end
// Accepts input items, classifies the operation and queues up to two commands.
// ----------------------------------------------------------------------------
module lzwvw_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  lzwvw_pkg::in_t  in_item,
    output logic            cmd_valid,
    output lzwvw_pkg::cmd_t cmd,
    input  logic            cmd_take
);

    lzwvw_pkg::cmd_t slot_reg [2];
    logic            wptr_reg, wptr_next;
    logic            rptr_reg, rptr_next;
    logic [1:0]      cnt_reg, cnt_next;
    logic            wr, rd;
    lzwvw_pkg::cmd_t classified;

    always_comb
    begin
        classified.data = in_item.data_byte;
        case (in_item.operation)
            lzwvw_pkg::OP_START: classified.kind = lzwvw_pkg::OP_START;
            lzwvw_pkg::OP_FEED:  classified.kind = lzwvw_pkg::OP_FEED;
            lzwvw_pkg::OP_PULL:  classified.kind = lzwvw_pkg::OP_PULL;
            default:             classified.kind = lzwvw_pkg::OP_NONE;
        endcase
    end

    assign full      = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = slot_reg[rptr_reg];
    assign wr        = push && !full;
    assign rd        = cmd_take && cmd_valid;

    always_comb
    begin
        wptr_next = wr ? !wptr_reg : wptr_reg;
        rptr_next = rd ? !rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + {1'b0, wr} - {1'b0, rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slot_reg[wptr_reg] <= classified;
        end
    end

endmodule

// File: rtl/core/lzwvw_back.sv
// ----------------------------------------------------------------------------
// LZW decoder back end
// Executes commands: stream start, bit unpacking, code handling, chain walk, byte pulls.
// ----------------------------------------------------------------------------
module lzwvw_back #(
    parameter int DICT_DEPTH  = 2048,
    parameter int STACK_DEPTH = 2048,
    parameter int WALK_LIMIT  = 4000
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    input  lzwvw_pkg::cmd_t cmd,
    output logic            cmd_take,
    input  logic [19:0]     output_length,
    output logic            res_valid,
    output lzwvw_pkg::out_t res,
    input  logic            res_ready
);

    localparam int DAW = $clog2(DICT_DEPTH);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int SCW = $clog2(STACK_DEPTH + 1);
    localparam int STW = $clog2(WALK_LIMIT + 2);
    localparam logic [11:0]    DICT_TOP  = 12'(DICT_DEPTH);
    localparam logic [SCW-1:0] STACK_TOP = SCW'(STACK_DEPTH);
    localparam logic [STW-1:0] STEP_TOP  = STW'(WALK_LIMIT);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_PULL = 2'd2;
    localparam logic [1:0] S_RESP = 2'd3;

    logic [1:0]      state_reg, state_next;
    logic [17:0]     bbuf_reg, bbuf_next;
    logic [4:0]      bcnt_reg, bcnt_next;
    logic [3:0]      width_reg, width_next;
    logic [11:0]     nfree_reg, nfree_next;
    logic [10:0]     prev_reg, prev_next;
    logic [7:0]      fchar_reg, fchar_next;
    logic [1:0]      phase_reg, phase_next;
    logic [SCW-1:0]  scnt_reg, scnt_next;
    logic [19:0]     bout_reg, bout_next;
    logic [1:0]      fin_reg, fin_next;
    logic [10:0]     walk_reg, walk_next;
    logic [10:0]     code_reg, code_next;
    logic [STW-1:0]  steps_reg, steps_next;
    lzwvw_pkg::out_t res_reg, res_next;

    logic            st_we;
    logic [SAW-1:0]  st_waddr;
    logic [7:0]      st_wdata;
    logic [7:0]      st_rdata;
    logic [SCW-1:0]  scnt_m1;
    logic            d_we;
    logic [18:0]     d_wdata;
    logic [18:0]     d_rdata;

    logic [17:0]     ext;
    logic [4:0]      cnt8;
    logic [10:0]     code;
    logic [11:0]     wlimit;
    logic            ent_ok;
    logic [7:0]      sfx;
    logic [10:0]     pfx;
    logic [STW-1:0]  steps_inc;
    logic [19:0]     bout_inc;

    assign scnt_m1   = scnt_reg - SCW'(1);
    assign st_waddr  = scnt_reg[SAW-1:0];
    assign ext       = bbuf_reg | (18'(cmd.data) << bcnt_reg);
    assign cnt8      = bcnt_reg + 5'd8;
    assign code      = 11'(ext & ((18'd1 << width_reg) - 18'd1));
    assign wlimit    = (12'd1 << width_reg) - 12'd2;
    assign ent_ok    = ({1'b0, walk_reg} < DICT_TOP) && (walk_reg != lzwvw_pkg::CLEAR_CODE);
    assign sfx       = ent_ok ? d_rdata[7:0] : 8'd0;
    assign pfx       = ent_ok ? d_rdata[18:8] : 11'd0;
    assign steps_inc = steps_reg + STW'(1);
    assign bout_inc  = bout_reg + 20'd1;
    assign d_wdata   = {prev_reg, walk_reg[7:0]};
    assign res       = res_reg;
    assign res_valid = (state_reg == S_RESP);

    always_comb
    begin
        state_next = state_reg;
        bbuf_next  = bbuf_reg;
        bcnt_next  = bcnt_reg;
        width_next = width_reg;
        nfree_next = nfree_reg;
        prev_next  = prev_reg;
        fchar_next = fchar_reg;
        phase_next = phase_reg;
        scnt_next  = scnt_reg;
        bout_next  = bout_reg;
        fin_next   = fin_reg;
        walk_next  = walk_reg;
        code_next  = code_reg;
        steps_next = steps_reg;
        res_next   = res_reg;
        cmd_take   = 1'b0;
        st_we      = 1'b0;
        st_wdata   = fchar_reg;
        d_we       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_take   = 1'b1;
                    state_next = S_RESP;
                    res_next   = '0;
                    case (cmd.kind)
                        lzwvw_pkg::OP_START:
                        begin
                            bbuf_next  = '0;
                            bcnt_next  = '0;
                            width_next = lzwvw_pkg::START_WIDTH;
                            nfree_next = lzwvw_pkg::FIRST_FREE;
                            prev_next  = '0;
                            fchar_next = '0;
                            phase_next = lzwvw_pkg::PH_FIRST;
                            scnt_next  = '0;
                            bout_next  = '0;
                            fin_next   = lzwvw_pkg::FS_RUNNING;
                        end
                        lzwvw_pkg::OP_FEED:
                        begin
                            res_next.accepted = 1'b1;
                            if (fin_reg != lzwvw_pkg::FS_RUNNING)
                            begin
                                res_next.accepted = 1'b1;
                            end
                            else if (scnt_reg != '0)
                            begin
                                res_next.accepted = 1'b0;
                            end
                            else if (bout_reg >= output_length)
                            begin
                                fin_next = lzwvw_pkg::FS_FULL;
                            end
                            else if (cnt8 < {1'b0, width_reg})
                            begin
                                bbuf_next = ext;
                                bcnt_next = cnt8;
                            end
                            else
                            begin
                                // a whole code is in hand
                                bbuf_next = ext >> width_reg;
                                bcnt_next = cnt8 - {1'b0, width_reg};
                                if (phase_reg == lzwvw_pkg::PH_FIRST)
                                begin
                                    prev_next  = code;
                                    fchar_next = code[7:0];
                                    phase_next = lzwvw_pkg::PH_NORMAL;
                                end
                                else if (phase_reg == lzwvw_pkg::PH_LITERAL)
                                begin
                                    prev_next  = code;
                                    fchar_next = code[7:0];
                                    st_we      = 1'b1;
                                    st_wdata   = code[7:0];
                                    scnt_next  = SCW'(1);
                                    phase_next = lzwvw_pkg::PH_NORMAL;
                                end
                                else if (code == lzwvw_pkg::END_CODE)
                                begin
                                    fin_next = lzwvw_pkg::FS_SHORT;
                                end
                                else if (code == lzwvw_pkg::CLEAR_CODE)
                                begin
                                    nfree_next = lzwvw_pkg::FREE_AFTER_CLEAR;
                                    width_next = lzwvw_pkg::START_WIDTH;
                                    phase_next = lzwvw_pkg::PH_LITERAL;
                                end
                                else
                                begin
                                    code_next  = code;
                                    steps_next = '0;
                                    state_next = S_WALK;
                                    if ({1'b0, code} >= nfree_reg)
                                    begin
                                        // code not yet defined: lead with first char
                                        st_we     = 1'b1;
                                        st_wdata  = fchar_reg;
                                        scnt_next = SCW'(1);
                                        walk_next = prev_reg;
                                    end
                                    else
                                    begin
                                        walk_next = code;
                                    end
                                end
                            end
                        end
                        lzwvw_pkg::OP_PULL:
                        begin
                            if (fin_reg == lzwvw_pkg::FS_RUNNING)
                            begin
                                if (bout_reg >= output_length)
                                begin
                                    fin_next  = lzwvw_pkg::FS_FULL;
                                    scnt_next = '0;
                                end
                                else if (scnt_reg != '0)
                                begin
                                    scnt_next           = scnt_m1;
                                    bout_next           = bout_inc;
                                    res_next.byte_valid = 1'b1;
                                    state_next          = S_PULL;
                                    if (bout_inc == output_length)
                                    begin
                                        res_next.last_byte = 1'b1;
                                        fin_next           = lzwvw_pkg::FS_FULL;
                                        scnt_next          = '0;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    res_next.status = fin_next;
                end
            end
            S_WALK:
            begin
                if (scnt_reg >= STACK_TOP)
                begin
                    fin_next   = lzwvw_pkg::FS_ERROR;
                    scnt_next  = '0;
                    state_next = S_RESP;
                end
                else if (walk_reg > lzwvw_pkg::LAST_LITERAL)
                begin
                    st_we      = 1'b1;
                    st_wdata   = sfx;
                    scnt_next  = scnt_reg + SCW'(1);
                    steps_next = steps_inc;
                    walk_next  = pfx;
                    if (steps_inc > STEP_TOP)
                    begin
                        fin_next   = lzwvw_pkg::FS_ERROR;
                        scnt_next  = '0;
                        state_next = S_RESP;
                    end
                end
                else
                begin
                    // chain root: finish the string and add the new entry if the dictionary has room
                    st_we      = 1'b1;
                    st_wdata   = walk_reg[7:0];
                    scnt_next  = scnt_reg + SCW'(1);
                    fchar_next = walk_reg[7:0];
                    if (nfree_reg > wlimit && width_reg != (lzwvw_pkg::WIDTH_STOP - 4'd1))
                    begin
                        width_next = width_reg + 4'd1;
                    end
                    d_we = (nfree_reg < DICT_TOP);
                    if (nfree_reg < lzwvw_pkg::NEXT_MAX)
                    begin
                        nfree_next = nfree_reg + 12'd1;
                    end
                    prev_next  = code_reg;
                    state_next = S_RESP;
                end
                res_next.status = fin_next;
            end
            S_PULL:
            begin
                res_next.out_byte = st_rdata;
                state_next        = S_RESP;
            end
            S_RESP:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            bbuf_reg  <= '0;
            bcnt_reg  <= '0;
            width_reg <= lzwvw_pkg::START_WIDTH;
            nfree_reg <= lzwvw_pkg::FIRST_FREE;
            prev_reg  <= '0;
            fchar_reg <= '0;
            phase_reg <= lzwvw_pkg::PH_FIRST;
            scnt_reg  <= '0;
            bout_reg  <= '0;
            fin_reg   <= lzwvw_pkg::FS_RUNNING;
            walk_reg  <= '0;
            code_reg  <= '0;
            steps_reg <= '0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            bbuf_reg  <= bbuf_next;
            bcnt_reg  <= bcnt_next;
            width_reg <= width_next;
            nfree_reg <= nfree_next;
            prev_reg  <= prev_next;
            fchar_reg <= fchar_next;
            phase_reg <= phase_next;
            scnt_reg  <= scnt_next;
            bout_reg  <= bout_next;
            fin_reg   <= fin_next;
            walk_reg  <= walk_next;
            code_reg  <= code_next;
            steps_reg <= steps_next;
            res_reg   <= res_next;
        end
    end

    lzwvw_ram #(
        .WIDTH(8),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (scnt_m1[SAW-1:0]),
        .rdata (st_rdata)
    );

    lzwvw_ram #(
        .WIDTH(19),
        .DEPTH(DICT_DEPTH)
    ) u_dict (
        .clk   (clk),
        .we    (d_we),
        .waddr (nfree_reg[DAW-1:0]),
        .wdata (d_wdata),
        .raddr (walk_next[DAW-1:0]),
        .rdata (d_rdata)
    );

endmodule

// File: rtl/core/lzwvw_checker.sv
// ----------------------------------------------------------------------------
// LZW decoder port checker
// Concurrent checks on what the top level ports show over time.
// ----------------------------------------------------------------------------
module lzwvw_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            empty,
    input logic            pop,
    input lzwvw_pkg::out_t out_item
);

    // A waiting result holds until popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_item)))
        else $error("result changed before pop");

    // A byte result never reports a taken feed
    a_byte_not_feed: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_item.byte_valid) |-> !out_item.accepted)
        else $error("byte result flagged as accepted feed");

    // The last byte is a valid byte and finishes the stream
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_item.last_byte) |->
            (out_item.byte_valid && out_item.status == lzwvw_pkg::FS_FULL))
        else $error("last byte without full finish");

    // A byte only comes out of a running or just-filled stream
    a_byte_status: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_item.byte_valid) |->
            (out_item.status == lzwvw_pkg::FS_RUNNING ||
             out_item.status == lzwvw_pkg::FS_FULL))
        else $error("byte out of a stopped stream");

endmodule

bind lzw_variable_width_decompressor lzwvw_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
);
